FILE: hdl/tsq_pkg.sv
// ----------------------------------------------------------------------------
// tsq_pkg: tone sequencer types, note ROM and track table
// Command codes, the note ROM (frequency, duration) and the span table that
// locates each music track and sound effect inside the ROM.
// ----------------------------------------------------------------------------
package tsq_pkg;

    localparam int FREQ_W   = 11;
    localparam int DUR_W    = 9;
    localparam int ELAPSE_W = 10;
    localparam int ADDR_W   = 8;
    localparam int SPAN_W   = 4;
    localparam int LEN_W    = 6;
    localparam int MIDX_W   = 5;
    localparam int EIDX_W   = 3;

    localparam logic [SPAN_W-1:0] EFFECT_SPAN_BASE = 4'd4;

    typedef enum logic [1:0] {
        MODE_TICK   = 2'd0,
        MODE_MUSIC  = 2'd1,
        MODE_EFFECT = 2'd2,
        MODE_STOP   = 2'd3
    } t_mode;

    typedef struct packed {
        logic [FREQ_W-1:0] freq;
        logic [DUR_W-1:0]  dur;
    } t_note;

    typedef struct packed {
        logic [FREQ_W-1:0] tone_freq;
        logic              effect_playing;
        logic              music_playing;
    } t_result;

    function automatic logic [ADDR_W-1:0] span_base(input logic [SPAN_W-1:0] s);
        case (s)
            4'd0:    span_base = 8'd0;
            4'd1:    span_base = 8'd0;
            4'd2:    span_base = 8'd32;
            4'd3:    span_base = 8'd60;
            4'd4:    span_base = 8'd88;
            4'd5:    span_base = 8'd91;
            4'd6:    span_base = 8'd95;
            4'd7:    span_base = 8'd98;
            4'd8:    span_base = 8'd103;
            4'd9:    span_base = 8'd106;
            4'd10:   span_base = 8'd110;
            4'd11:   span_base = 8'd112;
            default: span_base = 8'd0;
        endcase
    endfunction

    function automatic logic [LEN_W-1:0] span_len(input logic [SPAN_W-1:0] s);
        case (s)
            4'd0:    span_len = 6'd32;
            4'd1:    span_len = 6'd32;
            4'd2:    span_len = 6'd28;
            4'd3:    span_len = 6'd28;
            4'd4:    span_len = 6'd3;
            4'd5:    span_len = 6'd4;
            4'd6:    span_len = 6'd3;
            4'd7:    span_len = 6'd5;
            4'd8:    span_len = 6'd3;
            4'd9:    span_len = 6'd4;
            4'd10:   span_len = 6'd2;
            4'd11:   span_len = 6'd2;
            default: span_len = 6'd0;
        endcase
    endfunction

    function automatic t_note note_rom(input logic [ADDR_W-1:0] a);
        case (a)
            8'd0:   note_rom = {11'd659, 9'd220};  8'd1:   note_rom = {11'd784, 9'd220};
            8'd2:   note_rom = {11'd880, 9'd220};  8'd3:   note_rom = {11'd784, 9'd220};
            8'd4:   note_rom = {11'd659, 9'd220};  8'd5:   note_rom = {11'd587, 9'd220};
            8'd6:   note_rom = {11'd523, 9'd220};  8'd7:   note_rom = {11'd587, 9'd220};
            8'd8:   note_rom = {11'd659, 9'd220};  8'd9:   note_rom = {11'd784, 9'd220};
            8'd10:  note_rom = {11'd659, 9'd220};  8'd11:  note_rom = {11'd523, 9'd220};
            8'd12:  note_rom = {11'd587, 9'd220};  8'd13:  note_rom = {11'd659, 9'd220};
            8'd14:  note_rom = {11'd587, 9'd220};  8'd15:  note_rom = {11'd523, 9'd220};
            8'd16:  note_rom = {11'd659, 9'd220};  8'd17:  note_rom = {11'd784, 9'd220};
            8'd18:  note_rom = {11'd880, 9'd220};  8'd19:  note_rom = {11'd1047, 9'd220};
            8'd20:  note_rom = {11'd988, 9'd220};  8'd21:  note_rom = {11'd880, 9'd220};
            8'd22:  note_rom = {11'd784, 9'd220};  8'd23:  note_rom = {11'd659, 9'd220};
            8'd24:  note_rom = {11'd698, 9'd220};  8'd25:  note_rom = {11'd659, 9'd220};
            8'd26:  note_rom = {11'd587, 9'd220};  8'd27:  note_rom = {11'd659, 9'd220};
            8'd28:  note_rom = {11'd523, 9'd220};  8'd29:  note_rom = {11'd587, 9'd220};
            8'd30:  note_rom = {11'd659, 9'd220};  8'd31:  note_rom = {11'd587, 9'd220};
            8'd32:  note_rom = {11'd392, 9'd230};  8'd33:  note_rom = {11'd494, 9'd115};
            8'd34:  note_rom = {11'd587, 9'd230};  8'd35:  note_rom = {11'd494, 9'd115};
            8'd36:  note_rom = {11'd523, 9'd230};  8'd37:  note_rom = {11'd392, 9'd115};
            8'd38:  note_rom = {11'd440, 9'd345};  8'd39:  note_rom = {11'd440, 9'd230};
            8'd40:  note_rom = {11'd523, 9'd115};  8'd41:  note_rom = {11'd659, 9'd230};
            8'd42:  note_rom = {11'd523, 9'd115};  8'd43:  note_rom = {11'd587, 9'd230};
            8'd44:  note_rom = {11'd440, 9'd115};  8'd45:  note_rom = {11'd494, 9'd345};
            8'd46:  note_rom = {11'd523, 9'd230};  8'd47:  note_rom = {11'd587, 9'd115};
            8'd48:  note_rom = {11'd659, 9'd230};  8'd49:  note_rom = {11'd523, 9'd115};
            8'd50:  note_rom = {11'd494, 9'd230};  8'd51:  note_rom = {11'd587, 9'd115};
            8'd52:  note_rom = {11'd392, 9'd345};  8'd53:  note_rom = {11'd440, 9'd230};
            8'd54:  note_rom = {11'd523, 9'd115};  8'd55:  note_rom = {11'd494, 9'd230};
            8'd56:  note_rom = {11'd440, 9'd115};  8'd57:  note_rom = {11'd392, 9'd230};
            8'd58:  note_rom = {11'd494, 9'd115};  8'd59:  note_rom = {11'd523, 9'd345};
            8'd60:  note_rom = {11'd392, 9'd175};  8'd61:  note_rom = {11'd440, 9'd175};
            8'd62:  note_rom = {11'd523, 9'd175};  8'd63:  note_rom = {11'd587, 9'd175};
            8'd64:  note_rom = {11'd659, 9'd175};  8'd65:  note_rom = {11'd587, 9'd175};
            8'd66:  note_rom = {11'd523, 9'd350};  8'd67:  note_rom = {11'd494, 9'd175};
            8'd68:  note_rom = {11'd523, 9'd175};  8'd69:  note_rom = {11'd587, 9'd175};
            8'd70:  note_rom = {11'd659, 9'd175};  8'd71:  note_rom = {11'd698, 9'd175};
            8'd72:  note_rom = {11'd659, 9'd175};  8'd73:  note_rom = {11'd587, 9'd350};
            8'd74:  note_rom = {11'd523, 9'd175};  8'd75:  note_rom = {11'd494, 9'd175};
            8'd76:  note_rom = {11'd440, 9'd175};  8'd77:  note_rom = {11'd494, 9'd175};
            8'd78:  note_rom = {11'd523, 9'd175};  8'd79:  note_rom = {11'd587, 9'd175};
            8'd80:  note_rom = {11'd659, 9'd350};  8'd81:  note_rom = {11'd587, 9'd175};
            8'd82:  note_rom = {11'd523, 9'd175};  8'd83:  note_rom = {11'd494, 9'd175};
            8'd84:  note_rom = {11'd440, 9'd175};  8'd85:  note_rom = {11'd392, 9'd175};
            8'd86:  note_rom = {11'd440, 9'd175};  8'd87:  note_rom = {11'd494, 9'd350};
            8'd88:  note_rom = {11'd523, 9'd80};   8'd89:  note_rom = {11'd659, 9'd80};
            8'd90:  note_rom = {11'd784, 9'd120};  8'd91:  note_rom = {11'd880, 9'd150};
            8'd92:  note_rom = {11'd698, 9'd150};  8'd93:  note_rom = {11'd587, 9'd150};
            8'd94:  note_rom = {11'd494, 9'd300};  8'd95:  note_rom = {11'd523, 9'd100};
            8'd96:  note_rom = {11'd659, 9'd100};  8'd97:  note_rom = {11'd784, 9'd200};
            8'd98:  note_rom = {11'd523, 9'd80};   8'd99:  note_rom = {11'd659, 9'd80};
            8'd100: note_rom = {11'd784, 9'd80};   8'd101: note_rom = {11'd1047, 9'd80};
            8'd102: note_rom = {11'd1319, 9'd80};  8'd103: note_rom = {11'd1000, 9'd60};
            8'd104: note_rom = {11'd0, 9'd40};     8'd105: note_rom = {11'd1000, 9'd60};
            8'd106: note_rom = {11'd784, 9'd100};  8'd107: note_rom = {11'd1047, 9'd100};
            8'd108: note_rom = {11'd1319, 9'd100}; 8'd109: note_rom = {11'd1568, 9'd100};
            8'd110: note_rom = {11'd659, 9'd100};  8'd111: note_rom = {11'd523, 9'd100};
            8'd112: note_rom = {11'd988, 9'd25};   8'd113: note_rom = {11'd1319, 9'd35};
            default: note_rom = '0;
        endcase
    endfunction

endpackage

FILE: hdl/tone_sequencer_with_effect_preempt.sv
// ----------------------------------------------------------------------------
// tone_sequencer_with_effect_preempt: buzzer note sequencer
// Plays looping music tracks and one-shot sound effects from a note ROM.
//
// Input channel (i_valid / o_ready) carries one command per item: i_mode
// selects a one-millisecond tick, start of a music track, start of a sound
// effect, or stop; i_track names the track or effect. Each item yields one
// result item on the output channel (o_valid / i_ready): the tone frequency
// now driven and the effect and music status flags.
// Results are registered in the output (or, on a stall, the skid) register.
// One item is taken every cycle while o_ready is high; the sequencer state,
// a span table lookup and one note ROM read sit ahead of the result register.
// A two-entry result buffer (output register plus skid register) keeps the
// input open while a result waits; o_ready drops only once both hold results,
// i.e. after the receiver has stalled for two items.
// Reset clears the track, effect, timer and frequency (silent, no music) and
// empties the result buffer.
// ----------------------------------------------------------------------------
module tone_sequencer_with_effect_preempt #(
    parameter int NOTE_ROM_DEPTH = 128,
    parameter int MAX_TRACK_LEN  = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_mode,
    input  logic [2:0]  i_track,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [10:0] o_tone_freq,
    output logic        o_effect_playing,
    output logic        o_music_playing
);

    localparam logic [tsq_pkg::LEN_W-1:0]    LEN_MAX  = tsq_pkg::LEN_W'(MAX_TRACK_LEN);
    localparam logic [tsq_pkg::ADDR_W:0]     ROM_LIM  = (tsq_pkg::ADDR_W+1)'(NOTE_ROM_DEPTH);
    localparam logic [tsq_pkg::ELAPSE_W-1:0] ELAP_MAX = '1;

    logic [1:0]                   r_mtrack,  n_mtrack;
    logic [tsq_pkg::MIDX_W-1:0]   r_midx,    n_midx;
    logic [2:0]                   r_eid,     n_eid;
    logic [tsq_pkg::EIDX_W-1:0]   r_eidx,    n_eidx;
    logic                         r_eact,    n_eact;
    logic [tsq_pkg::ELAPSE_W-1:0] r_elapsed, n_elapsed;
    logic [tsq_pkg::DUR_W-1:0]    r_notelen, n_notelen;
    logic [tsq_pkg::FREQ_W-1:0]   r_freq,    n_freq;

    logic              r_out_vld, r_skid_vld;
    tsq_pkg::t_result  r_out, r_skid, res;

    logic                         accept;
    tsq_pkg::t_mode               mode;
    logic [tsq_pkg::SPAN_W-1:0]   eff_span, mus_span, play_span;
    logic [tsq_pkg::LEN_W-1:0]    eff_len, mus_len;
    logic [tsq_pkg::LEN_W-1:0]    eff_len_raw, mus_len_raw;
    logic [tsq_pkg::MIDX_W-1:0]   play_idx;
    logic                         play_en;
    logic [tsq_pkg::ADDR_W:0]     play_addr;
    tsq_pkg::t_note               note;
    logic [tsq_pkg::ELAPSE_W-1:0] el_inc;
    logic [tsq_pkg::EIDX_W-1:0]   eidx_inc;
    logic [tsq_pkg::LEN_W-1:0]    midx_inc;

    assign o_ready = !r_skid_vld;
    assign accept  = i_valid && o_ready;
    assign mode    = tsq_pkg::t_mode'(i_mode);

    assign eff_span    = tsq_pkg::EFFECT_SPAN_BASE + {1'b0, r_eid};
    assign mus_span    = {2'b00, r_mtrack};
    assign eff_len_raw = tsq_pkg::span_len(eff_span);
    assign mus_len_raw = tsq_pkg::span_len(mus_span);
    assign eff_len     = (eff_len_raw > LEN_MAX) ? LEN_MAX : eff_len_raw;
    assign mus_len     = (mus_len_raw > LEN_MAX) ? LEN_MAX : mus_len_raw;

    assign el_inc   = (r_elapsed == ELAP_MAX) ? r_elapsed : r_elapsed + 1'b1;
    assign eidx_inc = r_eidx + 1'b1;
    assign midx_inc = {1'b0, r_midx} + 1'b1;

    always_comb begin
        n_mtrack  = r_mtrack;
        n_midx    = r_midx;
        n_eid     = r_eid;
        n_eidx    = r_eidx;
        n_eact    = r_eact;
        n_elapsed = r_elapsed;
        n_notelen = r_notelen;
        n_freq    = r_freq;
        play_en   = 1'b0;
        play_span = '0;
        play_idx  = '0;
        case (mode)
            tsq_pkg::MODE_TICK: begin
                n_elapsed = el_inc;
                if (el_inc >= {1'b0, r_notelen}) begin
                    if (r_eact) begin
                        n_eidx = eidx_inc;
                        if ({3'b000, eidx_inc} < eff_len) begin
                            play_en   = 1'b1;
                            play_span = eff_span;
                            play_idx  = {2'b00, eidx_inc};
                        end else begin
                            n_eact = 1'b0;
                            if (r_mtrack != 2'd0) begin
                                play_en   = 1'b1;
                                play_span = mus_span;
                                play_idx  = r_midx;
                            end else begin
                                n_freq = '0;
                            end
                        end
                    end else if (r_mtrack != 2'd0) begin
                        n_midx    = (midx_inc >= mus_len) ? '0 : midx_inc[tsq_pkg::MIDX_W-1:0];
                        play_en   = 1'b1;
                        play_span = mus_span;
                        play_idx  = n_midx;
                    end
                end
            end
            tsq_pkg::MODE_MUSIC: begin
                n_eact = 1'b0;
                if (i_track == 3'd0) begin
                    n_freq   = '0;
                    n_mtrack = 2'd0;
                end else begin
                    n_mtrack  = (i_track > 3'd3) ? 2'd3 : i_track[1:0];
                    n_midx    = '0;
                    play_en   = 1'b1;
                    play_span = {2'b00, n_mtrack};
                end
            end
            tsq_pkg::MODE_EFFECT: begin
                n_eid     = i_track;
                n_eidx    = '0;
                n_eact    = 1'b1;
                play_en   = 1'b1;
                play_span = tsq_pkg::EFFECT_SPAN_BASE + {1'b0, i_track};
            end
            tsq_pkg::MODE_STOP: begin
                n_freq   = '0;
                n_mtrack = 2'd0;
                n_eact   = 1'b0;
            end
            default: begin
                n_freq = r_freq;
            end
        endcase

        play_addr = {1'b0, tsq_pkg::span_base(play_span)} + {4'b0000, play_idx};
        note      = tsq_pkg::note_rom(play_addr[tsq_pkg::ADDR_W-1:0]);
        if (play_en) begin
            if (play_addr < ROM_LIM) begin
                n_freq    = note.freq;
                n_notelen = note.dur;
            end else begin
                n_freq    = '0;
                n_notelen = '0;
            end
            n_elapsed = '0;
        end

        res.tone_freq      = n_freq;
        res.effect_playing = n_eact;
        res.music_playing  = (n_mtrack != 2'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mtrack  <= '0;
            r_midx    <= '0;
            r_eid     <= '0;
            r_eidx    <= '0;
            r_eact    <= 1'b0;
            r_elapsed <= '0;
            r_notelen <= '0;
            r_freq    <= '0;
        end else if (accept) begin
            r_mtrack  <= n_mtrack;
            r_midx    <= n_midx;
            r_eid     <= n_eid;
            r_eidx    <= n_eidx;
            r_eact    <= n_eact;
            r_elapsed <= n_elapsed;
            r_notelen <= n_notelen;
            r_freq    <= n_freq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (!r_out_vld || i_ready) begin
            if (r_skid_vld) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end else begin
                r_out_vld <= accept;
            end
        end else if (accept) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_vld || i_ready) begin
            r_out <= r_skid_vld ? r_skid : res;
        end else if (accept) begin
            r_skid <= res;
        end
    end

    assign o_valid          = r_out_vld;
    assign o_tone_freq      = r_out.tone_freq;
    assign o_effect_playing = r_out.effect_playing;
    assign o_music_playing  = r_out.music_playing;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid holds an item while the output register is empty");

    a_accept_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (!r_out_vld || i_ready)) |=> o_valid)
        else $error("accepted item did not reach the output");

    a_midx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mtrack != 2'd0) |-> ({1'b0, r_midx} < mus_len))
        else $error("music index beyond track length");

    a_eidx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_eact |-> ({3'b000, r_eidx} < eff_len))
        else $error("effect index beyond effect length");

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the buzzer tone sequencer
// Feeds ticks, track starts, effect starts and stops through the command
// channel, predicts each tone and status item from an independent note table
// and sequencer model, and compares every result item field by field. Both
// channels idle at random, apart from one stretch where they do not.
// ----------------------------------------------------------------------------
module tb;

    typedef struct {
        tsq_pkg::t_mode mode;
        logic [2:0]     track;
    } t_tone_cmd;

    localparam int NOTE_CNT = 114;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        i_valid  = 1'b0;
    logic [1:0]  i_mode   = tsq_pkg::MODE_TICK;
    logic [2:0]  i_track  = 3'd0;
    logic        i_ready  = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [10:0] o_tone_freq;
    logic        o_effect_playing;
    logic        o_music_playing;

    logic [10:0] note_hz [0:NOTE_CNT-1] = '{
        659, 784, 880, 784, 659, 587, 523, 587, 659, 784, 659, 523, 587, 659, 587, 523,
        659, 784, 880, 1047, 988, 880, 784, 659, 698, 659, 587, 659, 523, 587, 659, 587,
        392, 494, 587, 494, 523, 392, 440, 440, 523, 659, 523, 587, 440, 494,
        523, 587, 659, 523, 494, 587, 392, 440, 523, 494, 440, 392, 494, 523,
        392, 440, 523, 587, 659, 587, 523, 494, 523, 587, 659, 698, 659, 587,
        523, 494, 440, 494, 523, 587, 659, 587, 523, 494, 440, 392, 440, 494,
        523, 659, 784, 880, 698, 587, 494, 523, 659, 784, 523, 659, 784, 1047, 1319,
        1000, 0, 1000, 784, 1047, 1319, 1568, 659, 523, 988, 1319
    };
    logic [8:0] note_ms [0:NOTE_CNT-1] = '{
        220, 220, 220, 220, 220, 220, 220, 220, 220, 220, 220, 220, 220, 220, 220, 220,
        220, 220, 220, 220, 220, 220, 220, 220, 220, 220, 220, 220, 220, 220, 220, 220,
        230, 115, 230, 115, 230, 115, 345, 230, 115, 230, 115, 230, 115, 345,
        230, 115, 230, 115, 230, 115, 345, 230, 115, 230, 115, 230, 115, 345,
        175, 175, 175, 175, 175, 175, 350, 175, 175, 175, 175, 175, 175, 350,
        175, 175, 175, 175, 175, 175, 350, 175, 175, 175, 175, 175, 175, 350,
        80, 80, 120, 150, 150, 150, 300, 100, 100, 200, 80, 80, 80, 80, 80,
        60, 40, 60, 100, 100, 100, 100, 100, 100, 25, 35
    };
    int part_base [0:11] = '{0, 0, 32, 60, 88, 91, 95, 98, 103, 106, 110, 112};
    int part_len  [0:11] = '{32, 32, 28, 28, 3, 4, 3, 5, 3, 4, 2, 2};

    logic [1:0]  seq_track;
    logic [4:0]  seq_music_idx;
    logic [2:0]  seq_fx_id;
    logic [2:0]  seq_fx_idx;
    logic        seq_fx_on;
    logic [9:0]  seq_elapsed;
    logic [8:0]  seq_note_ms;
    logic [10:0] seq_hz;

    t_tone_cmd        cmd_queue [$];
    tsq_pkg::t_result tone_expect [$];
    logic        cmd_taken = 1'b0;
    int unsigned cyc = 0;
    int          n_fail = 0;
    int          n_checked = 0;
    int          n_ticks = 0;
    int          n_commands = 0;
    int          n_fx_ends = 0;
    int          n_wraps = 0;

    tone_sequencer_with_effect_preempt dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_mode           (i_mode),
        .i_track          (i_track),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_tone_freq      (o_tone_freq),
        .o_effect_playing (o_effect_playing),
        .o_music_playing  (o_music_playing)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic bit calm_window();
        return cyc >= 400 && cyc < 900;
    endfunction

    task automatic cue_note(input int part, input int idx);
        int addr;
        addr = part_base[part] + idx;
        if (addr < NOTE_CNT) begin
            seq_hz      = note_hz[addr];
            seq_note_ms = note_ms[addr];
        end else begin
            seq_hz      = '0;
            seq_note_ms = '0;
        end
        seq_elapsed = '0;
    endtask

    task automatic silence_all();
        seq_hz    = '0;
        seq_track = '0;
        seq_fx_on = 1'b0;
    endtask

    task automatic sequencer_step(input tsq_pkg::t_mode mode, input logic [2:0] trk,
                                  output tsq_pkg::t_result res);
        case (mode)
            tsq_pkg::MODE_TICK: begin
                if (seq_elapsed < 10'd1023)
                    seq_elapsed = seq_elapsed + 10'd1;
                if (seq_elapsed >= seq_note_ms) begin
                    if (seq_fx_on) begin
                        seq_fx_idx = seq_fx_idx + 3'd1;
                        if (seq_fx_idx < part_len[4 + seq_fx_id]) begin
                            cue_note(4 + seq_fx_id, seq_fx_idx);
                        end else begin
                            seq_fx_on = 1'b0;
                            n_fx_ends++;
                            if (seq_track != 0)
                                cue_note(seq_track, seq_music_idx);
                            else
                                seq_hz = '0;
                        end
                    end else if (seq_track != 0) begin
                        seq_music_idx = (int'(seq_music_idx) + 1) % part_len[seq_track];
                        if (seq_music_idx == 0)
                            n_wraps++;
                        cue_note(seq_track, seq_music_idx);
                    end
                end
            end
            tsq_pkg::MODE_MUSIC: begin
                seq_fx_on = 1'b0;
                if (trk == 0) begin
                    silence_all();
                end else begin
                    seq_track     = (trk > 3) ? 2'd3 : trk[1:0];
                    seq_music_idx = '0;
                    cue_note(seq_track, 0);
                end
            end
            tsq_pkg::MODE_EFFECT: begin
                seq_fx_id  = trk;
                seq_fx_idx = '0;
                seq_fx_on  = 1'b1;
                cue_note(4 + trk, 0);
            end
            default: silence_all();
        endcase
        res.tone_freq      = seq_hz;
        res.effect_playing = seq_fx_on;
        res.music_playing  = (seq_track != 0);
    endtask

    always @(posedge i_clk) begin
        tsq_pkg::t_result want;
        tsq_pkg::t_result got;
        cyc <= cyc + 1;
        if (!i_rst_n) begin
            seq_track     = '0;
            seq_music_idx = '0;
            seq_fx_id     = '0;
            seq_fx_idx    = '0;
            seq_fx_on     = 1'b0;
            seq_elapsed   = '0;
            seq_note_ms   = '0;
            seq_hz        = '0;
            cmd_taken    <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (tone_expect.size() == 0) begin
                    $error("result item with no command pending: freq %0d", o_tone_freq);
                    n_fail++;
                end else begin
                    want = tone_expect.pop_front();
                    got.tone_freq      = o_tone_freq;
                    got.effect_playing = o_effect_playing;
                    got.music_playing  = o_music_playing;
                    n_checked++;
                    if (got.tone_freq !== want.tone_freq) begin
                        $error("tone_freq: expected %0d, got %0d",
                               want.tone_freq, got.tone_freq);
                        n_fail++;
                    end
                    if (got.effect_playing !== want.effect_playing) begin
                        $error("effect_playing: expected %0b, got %0b",
                               want.effect_playing, got.effect_playing);
                        n_fail++;
                    end
                    if (got.music_playing !== want.music_playing) begin
                        $error("music_playing: expected %0b, got %0b",
                               want.music_playing, got.music_playing);
                        n_fail++;
                    end
                end
            end
            cmd_taken <= i_valid && o_ready;
            if (i_valid && o_ready) begin
                sequencer_step(tsq_pkg::t_mode'(i_mode), i_track, want);
                tone_expect.push_back(want);
                if (tsq_pkg::t_mode'(i_mode) == tsq_pkg::MODE_TICK)
                    n_ticks++;
                else
                    n_commands++;
            end
        end
    end

    always @(negedge i_clk) begin
        t_tone_cmd c;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_ready <= 1'b0;
        end else begin
            i_ready <= calm_window() || $urandom_range(99) >= 6;
            if (i_valid && !cmd_taken) begin
                i_valid <= 1'b1;
            end else if (cmd_queue.size() != 0 &&
                         (calm_window() || $urandom_range(99) >= 6)) begin
                c = cmd_queue.pop_front();
                i_valid <= 1'b1;
                i_mode  <= c.mode;
                i_track <= c.track;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    task automatic queue_cmd(input tsq_pkg::t_mode mode, input int trk);
        t_tone_cmd c;
        c.mode  = mode;
        c.track = trk[2:0];
        cmd_queue.push_back(c);
    endtask

    task automatic queue_ticks(input int n);
        for (int k = 0; k < n; k++)
            queue_cmd(tsq_pkg::MODE_TICK, $urandom_range(7));
    endtask

    task automatic queue_random_part(input int target);
        int sel;
        int start;
        start = cmd_queue.size();
        while (cmd_queue.size() - start < target) begin
            sel = $urandom_range(99);
            if (sel < 30) begin
                queue_cmd(tsq_pkg::MODE_MUSIC, $urandom_range(7));
                queue_ticks($urandom_range(1, 250));
            end else if (sel < 55) begin
                queue_cmd(tsq_pkg::MODE_EFFECT, $urandom_range(7));
                queue_ticks($urandom_range(1, 300));
            end else if (sel < 75) begin
                queue_cmd(tsq_pkg::MODE_MUSIC, $urandom_range(1, 7));
                queue_ticks($urandom_range(100, 250));
                queue_cmd(tsq_pkg::MODE_EFFECT, $urandom_range(7));
                queue_ticks($urandom_range(60, 300));
            end else if (sel < 85) begin
                queue_cmd(tsq_pkg::MODE_STOP, $urandom_range(7));
                queue_ticks($urandom_range(1, 30));
            end else begin
                repeat ($urandom_range(1, 8))
                    queue_cmd(tsq_pkg::t_mode'($urandom_range(3)), $urandom_range(7));
            end
        end
    endtask

    initial begin
        queue_cmd(tsq_pkg::MODE_TICK, 0);
        queue_cmd(tsq_pkg::MODE_STOP, 0);
        queue_cmd(tsq_pkg::MODE_EFFECT, 7);
        queue_cmd(tsq_pkg::MODE_MUSIC, 0);
        queue_cmd(tsq_pkg::MODE_MUSIC, 5);
        queue_cmd(tsq_pkg::MODE_MUSIC, 7);
        queue_cmd(tsq_pkg::MODE_MUSIC, 4);
        queue_cmd(tsq_pkg::MODE_MUSIC, 6);
        queue_cmd(tsq_pkg::MODE_MUSIC, 1);
        queue_cmd(tsq_pkg::MODE_EFFECT, 0);
        queue_cmd(tsq_pkg::MODE_TICK, 7);
        queue_cmd(tsq_pkg::MODE_MUSIC, 2);
        queue_cmd(tsq_pkg::MODE_EFFECT, 4);
        queue_cmd(tsq_pkg::MODE_EFFECT, 1);
        queue_cmd(tsq_pkg::MODE_STOP, 7);
        queue_cmd(tsq_pkg::MODE_TICK, 5);
        queue_cmd(tsq_pkg::MODE_EFFECT, 5);
        queue_cmd(tsq_pkg::MODE_EFFECT, 6);
        queue_cmd(tsq_pkg::MODE_EFFECT, 3);
        queue_cmd(tsq_pkg::MODE_EFFECT, 2);
        queue_cmd(tsq_pkg::MODE_MUSIC, 3);
        queue_cmd(tsq_pkg::MODE_STOP, 2);
        queue_cmd(tsq_pkg::MODE_TICK, 3);

        queue_random_part(1150);

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_queue.size() != 0 || i_valid)
            @(posedge i_clk);
        while (tone_expect.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        $display("covered %0d ticks and %0d commands, %0d result items checked",
                 n_ticks, n_commands, n_checked);
        $display("effects ran out %0d times, music tracks wrapped %0d times",
                 n_fx_ends, n_wraps);
        if (n_fail == 0 && tone_expect.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #(12 * 300000);
        $display("FAIL");
        $finish;
    end

endmodule

FILE: tone_sequencer_with_effect_preempt.f
hdl/tsq_pkg.sv
hdl/tone_sequencer_with_effect_preempt.sv
tb/tb.sv
